@@ rtl/core/rv32i_subset_execute_core_macros.svh @@
// Assertion macros shared by the execute core RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef RV32I_SUBSET_EXECUTE_CORE_MACROS_SVH
`define RV32I_SUBSET_EXECUTE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define RVX_ASSERT_IMP(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define RVX_ASSERT_NXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rvx_pkg.sv @@
// Shared types, opcodes and field codes of the RV32I subset execute core.
// Depends on nothing; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package rvx_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int REG_AW    = $clog2(REG_COUNT);

  // Fixed ABI register indexes
  localparam logic [REG_AW-1:0] REG_ZERO = REG_AW'(0);
  localparam logic [REG_AW-1:0] REG_A0   = REG_AW'(10);
  localparam logic [REG_AW-1:0] REG_A7   = REG_AW'(17);

  // System call numbers in a7
  localparam logic [XLEN-1:0] SYS_PRINT_INT = XLEN'(1);
  localparam logic [XLEN-1:0] SYS_PRINT_STR = XLEN'(4);
  localparam logic [XLEN-1:0] SYS_EXIT      = XLEN'(10);

  // Major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB   = 3'd0;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_SB   = 3'd0;
  localparam logic [2:0] F3_SW   = 3'd2;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef enum logic {
    OP_EXEC     = 1'b0,
    OP_LOAD_RET = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    LK_NONE = 2'd0,
    LK_LB   = 2'd1,
    LK_LBU  = 2'd2,
    LK_LW   = 2'd3
  } ld_kind_t;

  typedef enum logic [1:0] {
    SC_NONE      = 2'd0,
    SC_PRINT_INT = 2'd1,
    SC_PRINT_STR = 2'd2,
    SC_EXIT      = 2'd3
  } sc_kind_t;

  typedef struct packed {
    logic [XLEN-1:0]        next_pc;
    logic                   mem_read;
    logic                   mem_write;
    logic                   mem_byte;
    logic [XLEN-1:0]        mem_addr;
    logic [XLEN-1:0]        mem_wdata;
    sc_kind_t               syscall_kind;
    logic signed [XLEN-1:0] syscall_arg;
    logic                   halted;
  } out_item_t;

endpackage

@@ rtl/core/rvx_in_if.sv @@
// Input channel of the execute core: valid/ready plus one instruction or load-return word.
// Depends on rvx_pkg for the data width.
`timescale 1ns / 1ps

interface rvx_in_if;
  import rvx_pkg::*;

  logic            valid;
  logic            ready;
  logic            operation;
  logic [XLEN-1:0] instr;
  logic [XLEN-1:0] load_data;

  modport source (output valid, output operation, output instr, output load_data,
                  input ready);
  modport sink   (input valid, input operation, input instr, input load_data,
                  output ready);
endinterface

@@ rtl/core/rvx_out_if.sv @@
// Result channel of the execute core: valid/ready plus next pc, memory request and syscall.
// Depends on rvx_pkg for the data width.
`timescale 1ns / 1ps

interface rvx_out_if;
  import rvx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [XLEN-1:0]        next_pc;
  logic                   mem_read;
  logic                   mem_write;
  logic                   mem_byte;
  logic [XLEN-1:0]        mem_addr;
  logic [XLEN-1:0]        mem_wdata;
  logic [1:0]             syscall_kind;
  logic signed [XLEN-1:0] syscall_arg;
  logic                   halted;

  modport source (output valid, output next_pc, output mem_read, output mem_write,
                  output mem_byte, output mem_addr, output mem_wdata,
                  output syscall_kind, output syscall_arg, output halted,
                  input ready);
  modport sink   (input valid, input next_pc, input mem_read, input mem_write,
                  input mem_byte, input mem_addr, input mem_wdata,
                  input syscall_kind, input syscall_arg, input halted,
                  output ready);
endinterface

@@ rtl/core/rv32i_subset_execute_core.sv @@
// An accepted word passes the execute register, then the result register, before its result
// is valid. Throughput: one word per cycle unless the result channel stalls. The register
// file is read at accept, written as the word leaves the execute stage, with a one-entry bypass.
// Reset (rst_n low, synchronous): pc, halted flag, pending load and both pipeline valids
// clear; per-entry valid bits make every register read as zero until first written.
// The first word can be accepted in the cycle after reset is released.
`timescale 1ns / 1ps
`include "rv32i_subset_execute_core_macros.svh"

module rv32i_subset_execute_core (
  input  logic      clk,
  input  logic      rst_n,
  rvx_in_if.sink    in_chan,
  rvx_out_if.source out_chan
);
  import rvx_pkg::*;

  // Pipeline control
  logic in_fire;
  logic e_fire;
  logic in_ready;

  // Execute-stage registers
  logic              e_valid_r;
  op_t               e_op_r;
  logic [XLEN-1:0]   e_instr_r;
  logic [XLEN-1:0]   e_ld_r;
  logic [XLEN-1:0]   rf_q1_r;
  logic [XLEN-1:0]   rf_q2_r;
  logic              e_vld1_r;
  logic              e_vld2_r;
  logic              e_hit1_r;
  logic              e_hit2_r;
  logic [XLEN-1:0]   e_fwd_r;

  // Architectural state
  logic [XLEN-1:0]   rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  logic [XLEN-1:0]   a0_r;
  logic [XLEN-1:0]   a7_r;
  logic [XLEN-1:0]   pc_r;
  logic [XLEN-1:0]   pc_nxt;
  logic              stopped_r;
  logic              stopped_nxt;
  logic [REG_AW-1:0] pend_dest_r;
  logic [REG_AW-1:0] pend_dest_nxt;
  ld_kind_t          pend_kind_r;
  ld_kind_t          pend_kind_nxt;

  // Result register
  logic              out_valid_r;
  out_item_t         out_r;
  out_item_t         out_nxt;

  // Write-back port
  logic              wr_en;
  logic [REG_AW-1:0] wr_addr;
  logic [XLEN-1:0]   wr_data;
  logic              rf_we;

  // Input-side register indexes
  logic [REG_AW-1:0] in_rs1;
  logic [REG_AW-1:0] in_rs2;

  // Decode fields and operands
  logic [6:0]        opc;
  logic [REG_AW-1:0] rd;
  logic [2:0]        f3;
  logic [6:0]        f7;
  logic [4:0]        sh;
  logic [XLEN-1:0]   rs1_val;
  logic [XLEN-1:0]   rs2_val;
  logic [XLEN-1:0]   imm_i;
  logic [XLEN-1:0]   imm_s;
  logic [XLEN-1:0]   imm_b;
  logic [XLEN-1:0]   imm_j;
  logic [XLEN-1:0]   imm_u;
  logic [XLEN-1:0]   pc_plus4;
  logic [XLEN-1:0]   jalr_sum;
  logic              take;

  // Handshake: the execute stage advances when the result register is free or drains
  assign e_fire   = e_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !e_valid_r || e_fire;
  assign in_fire  = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  assign in_rs1 = in_chan.instr[19:15];
  assign in_rs2 = in_chan.instr[24:20];

  assign rf_we = e_fire && wr_en && (wr_addr != REG_ZERO);

  // Capture the incoming word and note any write-back landing in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (in_ready) begin
      e_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_op_r    <= op_t'(in_chan.operation);
      e_instr_r <= in_chan.instr;
      e_ld_r    <= in_chan.load_data;
      e_vld1_r  <= rf_vld_r[in_rs1];
      e_vld2_r  <= rf_vld_r[in_rs2];
      e_hit1_r  <= rf_we && (wr_addr == in_rs1);
      e_hit2_r  <= rf_we && (wr_addr == in_rs2);
      e_fwd_r   <= wr_data;
    end
  end

  // Register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      rf_q1_r <= rf_mem[in_rs1];
      rf_q2_r <= rf_mem[in_rs2];
    end
  end

  // Track written entries; an unwritten register reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[wr_addr] <= 1'b1;
    end
  end

  // Keep copies of a0 and a7 for the system call path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_r <= '0;
      a7_r <= '0;
    end else if (rf_we) begin
      if (wr_addr == REG_A0) begin
        a0_r <= wr_data;
      end
      if (wr_addr == REG_A7) begin
        a7_r <= wr_data;
      end
    end
  end

  // Decode fields and immediates
  always_comb begin
    opc      = e_instr_r[6:0];
    rd       = e_instr_r[11:7];
    f3       = e_instr_r[14:12];
    f7       = e_instr_r[31:25];
    sh       = e_instr_r[24:20];
    imm_i    = {{20{e_instr_r[31]}}, e_instr_r[31:20]};
    imm_s    = {{20{e_instr_r[31]}}, e_instr_r[31:25], e_instr_r[11:7]};
    imm_b    = {{19{e_instr_r[31]}}, e_instr_r[31], e_instr_r[7], e_instr_r[30:25],
                e_instr_r[11:8], 1'b0};
    imm_j    = {{11{e_instr_r[31]}}, e_instr_r[31], e_instr_r[19:12], e_instr_r[20],
                e_instr_r[30:21], 1'b0};
    imm_u    = {e_instr_r[31:12], 12'b0};
    rs1_val  = e_hit1_r ? e_fwd_r : (e_vld1_r ? rf_q1_r : '0);
    rs2_val  = e_hit2_r ? e_fwd_r : (e_vld2_r ? rf_q2_r : '0);
    pc_plus4 = pc_r + XLEN'(4);
    jalr_sum = rs1_val + imm_i;
  end

  // Execute one word: next pc, write-back, memory request, system call
  always_comb begin
    pc_nxt        = pc_r;
    stopped_nxt   = stopped_r;
    pend_dest_nxt = pend_dest_r;
    pend_kind_nxt = pend_kind_r;
    wr_en         = 1'b0;
    wr_addr       = rd;
    wr_data       = '0;
    take          = 1'b0;
    out_nxt       = '0;

    if (stopped_r) begin
      // halted: drop the word
    end else if (e_op_r == OP_LOAD_RET) begin
      wr_addr       = pend_dest_r;
      pend_kind_nxt = LK_NONE;
      case (pend_kind_r)
        LK_LB: begin
          wr_en   = 1'b1;
          wr_data = {{24{e_ld_r[7]}}, e_ld_r[7:0]};
        end
        LK_LBU: begin
          wr_en   = 1'b1;
          wr_data = {24'b0, e_ld_r[7:0]};
        end
        LK_LW: begin
          wr_en   = 1'b1;
          wr_data = e_ld_r;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end else begin
      pend_kind_nxt = LK_NONE;
      pc_nxt        = pc_plus4;
      case (opc)
        OPC_LUI: begin
          wr_en   = 1'b1;
          wr_data = imm_u;
        end
        OPC_AUIPC: begin
          wr_en   = 1'b1;
          wr_data = pc_r + imm_u;
        end
        OPC_JAL: begin
          wr_en   = 1'b1;
          wr_data = pc_plus4;
          pc_nxt  = pc_r + imm_j;
        end
        OPC_JALR: begin
          wr_en   = 1'b1;
          wr_data = pc_plus4;
          pc_nxt  = {jalr_sum[XLEN-1:1], 1'b0};
        end
        OPC_OP: begin
          case (f3)
            F3_ADD: begin
              if (f7 == F7_BASE) begin
                wr_en   = 1'b1;
                wr_data = rs1_val + rs2_val;
              end else if (f7 == F7_ALT) begin
                wr_en   = 1'b1;
                wr_data = rs1_val - rs2_val;
              end
            end
            F3_AND: begin
              wr_en   = 1'b1;
              wr_data = rs1_val & rs2_val;
            end
            F3_OR: begin
              wr_en   = 1'b1;
              wr_data = rs1_val | rs2_val;
            end
            F3_XOR: begin
              wr_en   = 1'b1;
              wr_data = rs1_val ^ rs2_val;
            end
            F3_SLT: begin
              wr_en   = 1'b1;
              wr_data = {31'b0, $signed(rs1_val) < $signed(rs2_val)};
            end
            F3_SLTU: begin
              wr_en   = 1'b1;
              wr_data = {31'b0, rs1_val < rs2_val};
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
        end
        OPC_OP_IMM: begin
          case (f3)
            F3_ADD: begin
              wr_en   = 1'b1;
              wr_data = rs1_val + imm_i;
            end
            F3_AND: begin
              wr_en   = 1'b1;
              wr_data = rs1_val & imm_i;
            end
            F3_OR: begin
              wr_en   = 1'b1;
              wr_data = rs1_val | imm_i;
            end
            F3_SLL: begin
              wr_en   = 1'b1;
              wr_data = rs1_val << sh;
            end
            F3_SR: begin
              if (f7 == F7_BASE) begin
                wr_en   = 1'b1;
                wr_data = rs1_val >> sh;
              end else if (f7 == F7_ALT) begin
                wr_en   = 1'b1;
                wr_data = XLEN'($signed(rs1_val) >>> sh);
              end
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
        end
        OPC_BRANCH: begin
          case (f3)
            F3_BEQ:  take = (rs1_val == rs2_val);
            F3_BNE:  take = (rs1_val != rs2_val);
            F3_BLT:  take = ($signed(rs1_val) < $signed(rs2_val));
            F3_BGE:  take = !($signed(rs1_val) < $signed(rs2_val));
            F3_BLTU: take = (rs1_val < rs2_val);
            F3_BGEU: take = (rs1_val >= rs2_val);
            default: take = 1'b0;
          endcase
          if (take) begin
            pc_nxt = pc_r + imm_b;
          end
        end
        OPC_LOAD: begin
          if (f3 == F3_LB || f3 == F3_LBU || f3 == F3_LW) begin
            out_nxt.mem_read = 1'b1;
            out_nxt.mem_byte = (f3 != F3_LW);
            out_nxt.mem_addr = rs1_val + imm_i;
            pend_dest_nxt    = rd;
            pend_kind_nxt    = (f3 == F3_LB)  ? LK_LB :
                               (f3 == F3_LBU) ? LK_LBU : LK_LW;
          end
        end
        OPC_STORE: begin
          if (f3 == F3_SB || f3 == F3_SW) begin
            out_nxt.mem_write = 1'b1;
            out_nxt.mem_byte  = (f3 == F3_SB);
            out_nxt.mem_addr  = rs1_val + imm_s;
            out_nxt.mem_wdata = (f3 == F3_SB) ? {24'b0, rs2_val[7:0]} : rs2_val;
          end
        end
        OPC_SYSTEM: begin
          if (a7_r == SYS_PRINT_INT) begin
            out_nxt.syscall_kind = SC_PRINT_INT;
            out_nxt.syscall_arg  = a0_r;
          end else if (a7_r == SYS_PRINT_STR) begin
            out_nxt.syscall_kind = SC_PRINT_STR;
            out_nxt.syscall_arg  = a0_r;
          end else if (a7_r == SYS_EXIT) begin
            out_nxt.syscall_kind = SC_EXIT;
            out_nxt.syscall_arg  = a0_r;
            stopped_nxt          = 1'b1;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end

    out_nxt.next_pc = pc_nxt;
    out_nxt.halted  = stopped_nxt;
  end

  // Commit architectural state as the word leaves the execute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      stopped_r   <= 1'b0;
      pend_dest_r <= '0;
      pend_kind_r <= LK_NONE;
    end else if (e_fire) begin
      pc_r        <= pc_nxt;
      stopped_r   <= stopped_nxt;
      pend_dest_r <= pend_dest_nxt;
      pend_kind_r <= pend_kind_nxt;
    end
  end

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.next_pc      = out_r.next_pc;
  assign out_chan.mem_read     = out_r.mem_read;
  assign out_chan.mem_write    = out_r.mem_write;
  assign out_chan.mem_byte     = out_r.mem_byte;
  assign out_chan.mem_addr     = out_r.mem_addr;
  assign out_chan.mem_wdata    = out_r.mem_wdata;
  assign out_chan.syscall_kind = out_r.syscall_kind;
  assign out_chan.syscall_arg  = out_r.syscall_arg;
  assign out_chan.halted       = out_r.halted;

  // Checks
  `RVX_ASSERT_NXT(a_halt_sticky, clk, rst_n, stopped_r, stopped_r, "halted flag cleared")
  `RVX_ASSERT_IMP(a_x0_never_written, clk, rst_n, 1'b1, !rf_vld_r[0], "x0 was written")
  `RVX_ASSERT_IMP(a_ready_when_free, clk, rst_n, !out_valid_r, in_ready,
                  "input stalled with empty result register")
  `RVX_ASSERT_IMP(a_one_mem_request, clk, rst_n, out_valid_r,
                  !(out_r.mem_read && out_r.mem_write), "load and store in one word")
  `RVX_ASSERT_NXT(a_load_ret_clears, clk, rst_n, e_fire && (e_op_r == OP_LOAD_RET),
                  pend_kind_r == LK_NONE, "pending load kept after load return")

endmodule

@@ sim/tb.sv @@
// Self-checking bench for the RV32I subset execute core: directed and random instruction words
// with load returns, checked field by field against an in-bench architectural model.
// Depends on rvx_pkg, rvx_in_if, rvx_out_if and rv32i_subset_execute_core.
`timescale 1ns / 1ps

module tb;
  import rvx_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam logic [2:0]  F3_HALF        = 3'd1;   // LH / SH, outside the subset
  localparam logic [2:0]  F3_JALR        = 3'd0;
  localparam logic [6:0]  OPC_UNKNOWN    = 7'h7F;

  logic clk;
  logic rst_n;

  rvx_in_if  in_chan ();
  rvx_out_if out_chan ();

  rv32i_subset_execute_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Architectural state as the core should see it
  logic [XLEN-1:0] arch_regs [REG_COUNT];
  logic [XLEN-1:0] arch_pc;
  logic            arch_halted;
  logic [4:0]      pend_rd;
  ld_kind_t        pend_kind;

  out_item_t predicted_retires [$];
  int        mismatches;
  int        quiet_cycles;
  int        burst_left;
  bit        gapless;
  int        rx_mode;
  int        rx_hold;

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register file access with x0 hardwired to zero
  function automatic logic [XLEN-1:0] rget(logic [4:0] idx);
    return (idx == REG_ZERO) ? '0 : arch_regs[idx];
  endfunction

  function automatic void rset(logic [4:0] idx, logic [XLEN-1:0] val);
    if (idx != REG_ZERO) arch_regs[idx] = val;
  endfunction

  // Retire one word on the model and return the result it must produce
  function automatic out_item_t retire_word(op_t op, logic [31:0] w, logic [31:0] ld);
    out_item_t       r;
    logic [31:0]     pc, a, b, immi, imms, immb, immj, a7, sra;
    logic [4:0]      rd, sh;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic            take;
    r    = '0;
    pc   = arch_pc;
    rd   = w[11:7];
    f3   = w[14:12];
    f7   = w[31:25];
    sh   = w[24:20];
    a    = rget(w[19:15]);
    b    = rget(w[24:20]);
    immi = {{20{w[31]}}, w[31:20]};
    imms = {{20{w[31]}}, w[31:25], w[11:7]};
    immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    take = 1'b0;
    r.next_pc = pc;
    if (arch_halted) begin
      // hold everything once exited
    end else if (op == OP_LOAD_RET) begin
      case (pend_kind)
        LK_LB:   rset(pend_rd, {{24{ld[7]}}, ld[7:0]});
        LK_LBU:  rset(pend_rd, {24'h0, ld[7:0]});
        LK_LW:   rset(pend_rd, ld);
        default: ;
      endcase
      pend_kind = LK_NONE;
    end else begin
      pend_kind = LK_NONE;
      r.next_pc = pc + 32'd4;
      case (w[6:0])
        OPC_LUI:   rset(rd, {w[31:12], 12'h0});
        OPC_AUIPC: rset(rd, pc + {w[31:12], 12'h0});
        OPC_JAL: begin
          rset(rd, pc + 32'd4);
          r.next_pc = pc + immj;
        end
        OPC_JALR: begin
          r.next_pc = (a + immi) & ~32'h1;
          rset(rd, pc + 32'd4);
        end
        OPC_OP: begin
          case (f3)
            F3_ADD: begin
              if (f7 == F7_BASE) rset(rd, a + b);
              else if (f7 == F7_ALT) rset(rd, a - b);
            end
            F3_AND:  rset(rd, a & b);
            F3_OR:   rset(rd, a | b);
            F3_XOR:  rset(rd, a ^ b);
            F3_SLT:  rset(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
            F3_SLTU: rset(rd, (a < b) ? 32'd1 : 32'd0);
            default: ;
          endcase
        end
        OPC_OP_IMM: begin
          case (f3)
            F3_ADD: rset(rd, a + immi);
            F3_AND: rset(rd, a & immi);
            F3_OR:  rset(rd, a | immi);
            F3_SLL: rset(rd, a << sh);
            F3_SR: begin
              sra = $signed(a) >>> sh;
              if (f7 == F7_BASE) rset(rd, a >> sh);
              else if (f7 == F7_ALT) rset(rd, sra);
            end
            default: ;
          endcase
        end
        OPC_BRANCH: begin
          case (f3)
            F3_BEQ:  take = (a == b);
            F3_BNE:  take = (a != b);
            F3_BLT:  take = ($signed(a) < $signed(b));
            F3_BGE:  take = !($signed(a) < $signed(b));
            F3_BLTU: take = (a < b);
            F3_BGEU: take = (a >= b);
            default: ;
          endcase
          if (take) r.next_pc = pc + immb;
        end
        OPC_LOAD: begin
          if (f3 == F3_LB || f3 == F3_LBU || f3 == F3_LW) begin
            r.mem_read = 1'b1;
            r.mem_byte = (f3 != F3_LW);
            r.mem_addr = a + immi;
            pend_rd    = rd;
            if (f3 == F3_LB) pend_kind = LK_LB;
            else if (f3 == F3_LBU) pend_kind = LK_LBU;
            else pend_kind = LK_LW;
          end
        end
        OPC_STORE: begin
          if (f3 == F3_SB || f3 == F3_SW) begin
            r.mem_write = 1'b1;
            r.mem_byte  = (f3 == F3_SB);
            r.mem_addr  = a + imms;
            r.mem_wdata = (f3 == F3_SB) ? {24'h0, b[7:0]} : b;
          end
        end
        OPC_SYSTEM: begin
          a7 = rget(REG_A7);
          if (a7 == SYS_PRINT_INT) r.syscall_kind = SC_PRINT_INT;
          else if (a7 == SYS_PRINT_STR) r.syscall_kind = SC_PRINT_STR;
          else if (a7 == SYS_EXIT) begin
            r.syscall_kind = SC_EXIT;
            arch_halted    = 1'b1;
          end
          if (r.syscall_kind != SC_NONE) r.syscall_arg = rget(REG_A0);
        end
        default: ;
      endcase
      arch_pc = r.next_pc;
    end
    r.halted = arch_halted;
    return r;
  endfunction

  // Instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  // Bias register picks toward the low registers x0-x7 so values get reused
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [6:0] pick_f7();
    case ($urandom_range(0, 3))
      0:       return F7_BASE;
      1:       return F7_ALT;
      default: return 7'($urandom);
    endcase
  endfunction

  // Build one random instruction word; never an exit while a7 holds the exit code
  function automatic logic [31:0] next_random_instr();
    logic [31:0] w, rnd;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    rnd = $urandom;
    rd  = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    f3  = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 15))
      0:     w = rnd;
      1:     w = {rnd[31:12], rd, OPC_LUI};
      2:     w = {rnd[31:12], rd, OPC_AUIPC};
      3:     w = enc_j(rnd[20:0], rd);
      4:     w = enc_i(rnd[11:0], rs1, F3_JALR, rd, OPC_JALR);
      5, 6:  w = enc_r(pick_f7(), rs2, rs1, f3, rd, OPC_OP);
      7, 8: begin
        w = enc_i(rnd[11:0], rs1, f3, rd, OPC_OP_IMM);
        if (f3 == F3_SLL || f3 == F3_SR) w[31:25] = pick_f7();
      end
      9, 10: w = enc_b(rnd[12:0], rs2, rs1, f3);
      11, 12: begin
        if ($urandom_range(0, 4) != 0) begin
          case ($urandom_range(0, 2))
            0:       f3 = F3_LB;
            1:       f3 = F3_LBU;
            default: f3 = F3_LW;
          endcase
        end
        w = enc_i(rnd[11:0], rs1, f3, rd, OPC_LOAD);
      end
      13: begin
        if ($urandom_range(0, 4) != 0) f3 = ($urandom_range(0, 1) == 0) ? F3_SB : F3_SW;
        w = enc_s(rnd[11:0], rs2, rs1, f3);
      end
      14:      w = {rnd[31:7], OPC_SYSTEM};
      default: w = enc_i(($urandom_range(0, 1) == 0) ? SYS_PRINT_INT[11:0] : SYS_PRINT_STR[11:0],
                         REG_ZERO, F3_ADD, REG_A7, OPC_OP_IMM);
    endcase
    if (w[6:0] == OPC_SYSTEM && rget(REG_A7) == SYS_EXIT) w[6:0] = OPC_OP_IMM;
    return w;
  endfunction

  // Send one word in bursts, with random gaps unless gapless; call and return at a falling edge
  task automatic send_word(op_t op, logic [31:0] w, logic [31:0] ld);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!gapless) begin
        gap = $urandom_range(1, 8);
        in_chan.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_chan.valid     = 1'b1;
    in_chan.operation = op;
    in_chan.instr     = w;
    in_chan.load_data = ld;
    do @(posedge clk); while (!in_chan.ready);
    predicted_retires.push_back(retire_word(op, w, ld));
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic drain_results();
    in_chan.valid = 1'b0;
    while (predicted_retires.size() != 0) @(negedge clk);
  endtask

  task automatic test_stray_return();
    send_word(OP_LOAD_RET, 32'h0, 32'hFFFF_FFFF);
  endtask

  task automatic test_upper_and_alu();
    send_word(OP_EXEC, {20'hFFFFF, 5'd1, OPC_LUI}, 32'h0);
    send_word(OP_EXEC, {20'hABCDE, REG_ZERO, OPC_LUI}, 32'h0);
    send_word(OP_EXEC, {20'h80000, 5'd2, OPC_AUIPC}, 32'h0);
    send_word(OP_EXEC, enc_i(12'h7FF, REG_ZERO, F3_ADD, 5'd3, OPC_OP_IMM), 32'h0);
    send_word(OP_EXEC, enc_i(12'h800, REG_ZERO, F3_ADD, 5'd4, OPC_OP_IMM), 32'h0);
    send_word(OP_EXEC, enc_r(F7_ALT, 5'd4, 5'd3, F3_ADD, 5'd5, OPC_OP), 32'h0);
    send_word(OP_EXEC, enc_r(F7_BASE, 5'd3, 5'd4, F3_SLT, 5'd6, OPC_OP), 32'h0);
    send_word(OP_EXEC, enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd7, OPC_OP_IMM), 32'h0);
    // unlisted encodings inside known opcodes
    send_word(OP_EXEC, enc_r(F7_BASE, 5'd3, 5'd1, F3_SLL, 5'd8, OPC_OP), 32'h0);
    send_word(OP_EXEC, enc_r(7'h01, 5'd3, 5'd1, F3_ADD, 5'd9, OPC_OP), 32'h0);
  endtask

  task automatic test_loads();
    send_word(OP_EXEC, enc_i(12'h000, REG_ZERO, F3_LB, 5'd11, OPC_LOAD), 32'h0);
    send_word(OP_LOAD_RET, 32'h0, 32'h0000_0080);
    send_word(OP_EXEC, enc_i(12'hFFF, 5'd1, F3_LBU, 5'd12, OPC_LOAD), 32'h0);
    send_word(OP_LOAD_RET, 32'h0, 32'hFFFF_FF80);
    send_word(OP_EXEC, enc_i(12'h7FF, 5'd3, F3_LW, 5'd13, OPC_LOAD), 32'h0);
    send_word(OP_LOAD_RET, 32'h0, 32'h8000_0001);
    // an instruction while a load is pending drops it
    send_word(OP_EXEC, enc_i(12'h800, 5'd1, F3_LW, 5'd14, OPC_LOAD), 32'h0);
    send_word(OP_EXEC, enc_i(12'h001, 5'd13, F3_ADD, 5'd15, OPC_OP_IMM), 32'h0);
    send_word(OP_LOAD_RET, 32'h0, 32'h1234_5678);
  endtask

  task automatic test_stores_and_flow();
    send_word(OP_EXEC, enc_s(12'h800, 5'd1, 5'd3, F3_SB), 32'h0);
    send_word(OP_EXEC, enc_s(12'h7FF, 5'd13, 5'd4, F3_SW), 32'h0);
    send_word(OP_EXEC, enc_s(12'h000, 5'd1, 5'd1, F3_HALF), 32'h0);
    send_word(OP_EXEC, enc_b(13'h1000, REG_ZERO, REG_ZERO, F3_BEQ), 32'h0);
    send_word(OP_EXEC, {25'h1FF_FFFF, OPC_UNKNOWN}, 32'h0);
    send_word(OP_EXEC, enc_j(21'h0F_FFFE, 5'd1), 32'h0);
    // odd target: bit 0 must clear
    send_word(OP_EXEC, enc_i(12'h000, 5'd3, F3_JALR, 5'd16, OPC_JALR), 32'h0);
  endtask

  task automatic test_syscalls();
    send_word(OP_EXEC, {25'h0, OPC_SYSTEM}, 32'h0);
    send_word(OP_EXEC, enc_i(SYS_PRINT_INT[11:0], REG_ZERO, F3_ADD, REG_A7, OPC_OP_IMM), 32'h0);
    send_word(OP_EXEC, {25'h0, OPC_SYSTEM}, 32'h0);
    send_word(OP_EXEC, enc_i(SYS_PRINT_STR[11:0], REG_ZERO, F3_ADD, REG_A7, OPC_OP_IMM), 32'h0);
    send_word(OP_EXEC, {25'h1FF_FFFF, OPC_SYSTEM}, 32'h0);
  endtask

  // Mostly well-formed programs, loads usually followed by their return word
  task automatic test_random_program(int n_items);
    int          sent;
    logic [31:0] w;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 4) begin
        if (pend_kind != LK_NONE) sent++;
        send_word(OP_LOAD_RET, $urandom, $urandom);
      end else begin
        w = next_random_instr();
        send_word(OP_EXEC, w, $urandom);
        sent++;
        if (pend_kind != LK_NONE && $urandom_range(0, 99) < 85) begin
          send_word(OP_LOAD_RET, $urandom, $urandom);
          sent++;
        end
      end
    end
  endtask

  // Exit, then everything after it must be ignored
  task automatic test_exit_halt();
    send_word(OP_EXEC, enc_i(12'hFFF, REG_ZERO, F3_ADD, REG_A0, OPC_OP_IMM), 32'h0);
    send_word(OP_EXEC, enc_i(SYS_EXIT[11:0], REG_ZERO, F3_ADD, REG_A7, OPC_OP_IMM), 32'h0);
    send_word(OP_EXEC, {25'h0, OPC_SYSTEM}, 32'h0);
    send_word(OP_EXEC, {20'h12345, 5'd1, OPC_LUI}, 32'h0);
    send_word(OP_EXEC, enc_i(12'h000, REG_ZERO, F3_LW, 5'd2, OPC_LOAD), 32'h0);
    send_word(OP_LOAD_RET, 32'h0, 32'hFFFF_FFFF);
  endtask

  // Receiver stalls: switch at random between four stall densities, from never to mostly stalling
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_hold = $urandom_range(16, 96);
    end
    rx_hold--;
    case (rx_mode)
      0:       out_chan.ready = 1'b1;
      1:       out_chan.ready = ($urandom_range(0, 1) == 0);
      2:       out_chan.ready = ($urandom_range(0, 3) != 0);
      default: out_chan.ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $error("%s: expected %h, got %h", name, exp_v, act_v);
    end
  endfunction

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (predicted_retires.size() == 0) begin
        mismatches++;
        $error("result word with no prediction: next_pc %h", out_chan.next_pc);
      end else begin
        e = predicted_retires.pop_front();
        check_field("next_pc", e.next_pc, out_chan.next_pc);
        check_field("mem_read", 32'(e.mem_read), 32'(out_chan.mem_read));
        check_field("mem_write", 32'(e.mem_write), 32'(out_chan.mem_write));
        check_field("mem_byte", 32'(e.mem_byte), 32'(out_chan.mem_byte));
        check_field("mem_addr", e.mem_addr, out_chan.mem_addr);
        check_field("mem_wdata", e.mem_wdata, out_chan.mem_wdata);
        check_field("syscall_kind", 32'(e.syscall_kind), 32'(out_chan.syscall_kind));
        check_field("syscall_arg", e.syscall_arg, out_chan.syscall_arg);
        check_field("halted", 32'(e.halted), 32'(out_chan.halted));
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_EXEC;
    in_chan.instr     = '0;
    in_chan.load_data = '0;
    out_chan.ready    = 1'b0;
    mismatches        = 0;
    quiet_cycles      = 0;
    burst_left        = 0;
    gapless           = 1'b0;
    rx_mode           = 0;
    rx_hold           = 0;
    for (int i = 0; i < REG_COUNT; i++) arch_regs[REG_AW'(i)] = '0;
    arch_pc     = '0;
    arch_halted = 1'b0;
    pend_rd     = '0;
    pend_kind   = LK_NONE;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_stray_return();
    test_upper_and_alu();
    test_loads();
    test_stores_and_flow();
    test_syscalls();
    test_random_program(400);
    drain_results();
    gapless = 1'b1;
    test_random_program(200);
    gapless = 1'b0;
    test_random_program(400);
    test_exit_halt();

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && predicted_retires.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ rv32i_subset_execute_core.f @@
+incdir+rtl/core
rtl/core/rvx_pkg.sv
rtl/core/rvx_in_if.sv
rtl/core/rvx_out_if.sv
rtl/core/rv32i_subset_execute_core.sv
sim/tb.sv
